@@ src/lrl_pkg.sv @@
// Shared types and constants for the LRU recency list.
// No dependencies; compiled first.
`default_nettype none

package lrl_pkg;

	localparam int KEY_W = 32;
	localparam int CNT_W = 4;

	localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 4'd8;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic probe;
		logic holds;
		logic shift;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/lrl_ifs.sv @@
// Valid/ready channel interfaces for access, result and configuration.
// Depends on lrl_pkg.
`default_nettype none

interface lrl_access_if;
	import lrl_pkg::*;
	logic valid;
	logic ready;
	key_t access_key;
	modport source (output valid, output access_key, input ready);
	modport sink (input valid, input access_key, output ready);
endinterface

interface lrl_result_if;
	import lrl_pkg::*;
	logic valid;
	logic ready;
	logic hit;
	logic evicted;
	key_t evicted_key;
	cnt_t fill_count;
	modport source (output valid, output hit, output evicted, output evicted_key,
		output fill_count, input ready);
	modport sink (input valid, input hit, input evicted, input evicted_key,
		input fill_count, output ready);
endinterface

interface lrl_cfg_if;
	import lrl_pkg::*;
	logic valid;
	logic ready;
	cnt_t max_entries;
	modport source (output valid, output max_entries, input ready);
	modport sink (input valid, input max_entries, output ready);
endinterface

`default_nettype wire

@@ src/lrl_cell.sv @@
// One list position: holds a key, compares it against a probe and takes its
// neighbor's key on a shift. Depends on lrl_pkg.
`default_nettype none

module lrl_cell (
	input  wire logic              clk,
	input  wire lrl_pkg::cell_ctrl_t ctrl,
	input  wire lrl_pkg::key_t     probe_key,
	input  wire lrl_pkg::key_t     prev_key,
	output lrl_pkg::key_t          key,
	output logic                   match
);
	import lrl_pkg::*;

	key_t key_q;
	logic match_s1;

	always_ff @(posedge clk) begin
		if (ctrl.probe) begin
			match_s1 <= ctrl.holds && (key_q == probe_key);
		end
		if (ctrl.shift) begin
			key_q <= prev_key;
		end
	end

	assign key = key_q;
	assign match = match_s1;

endmodule

`default_nettype wire

@@ src/lru_recency_list_top.sv @@
// LRU recency list: a row of cells ordered from most to least recently used.
// An access is registered into stage one; the result registers load when stage
// one advances, which stalls while a held result is not taken. A new access waits
// for an empty stage one. Cells compare on accept and shift toward the tail on advance.
// Reset empties the list and sets max_entries to 8; cell keys are not reset.
`default_nettype none

module lru_recency_list_top #(
	parameter int CAPACITY = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lrl_access_if.sink access,
	lrl_result_if.source result,
	lrl_cfg_if.sink    cfg
);
	import lrl_pkg::*;

	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (OCC_W > CNT_W) ? OCC_W : CNT_W;

	logic [OCC_W-1:0] occ_q;
	cnt_t             max_entries_q;
	logic             s1_valid_q;
	key_t             key_s1;

	logic             out_valid_q;
	logic             hit_q;
	logic             evicted_q;
	key_t             evicted_key_q;
	cnt_t             fill_count_q;

	logic             accept;
	logic             advance;
	logic [CAPACITY-1:0] match_vec;
	logic [CAPACITY-1:0] tail_sel;
	key_t             cell_key [CAPACITY];
	cell_ctrl_t       ctrl [CAPACITY];
	logic             hit;
	logic             room;
	logic [CMP_W-1:0] lim;
	key_t             tail_key;
	logic [OCC_W-1:0] occ_next;

	assign access.ready = !s1_valid_q;
	assign accept       = access.valid && access.ready;
	assign advance      = s1_valid_q && (!out_valid_q || result.ready);
	assign cfg.ready    = 1'b1;

	always_comb begin
		if (max_entries_q == '0) begin
			lim = CMP_W'(1);
		end else if (CMP_W'(max_entries_q) > CMP_W'(CAPACITY)) begin
			lim = CMP_W'(CAPACITY);
		end else begin
			lim = CMP_W'(max_entries_q);
		end
	end

	assign hit  = |match_vec;
	assign room = CMP_W'(occ_q) < lim;

	always_comb begin
		tail_key = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tail_key = tail_key | (cell_key[i] & {KEY_W{tail_sel[i]}});
		end
	end

	assign occ_next = (!hit && room) ? occ_q + OCC_W'(1) : occ_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign tail_sel[i]    = (OCC_W'(i + 1) == occ_q);
		assign ctrl[i].probe  = accept;
		assign ctrl[i].holds  = (OCC_W'(i) < occ_q);
		if (i == 0) begin : g_head
			assign ctrl[i].shift = advance;
			lrl_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl[i]),
				.probe_key (access.access_key),
				.prev_key  (key_s1),
				.key       (cell_key[i]),
				.match     (match_vec[i])
			);
		end else begin : g_body
			assign ctrl[i].shift = advance && (hit ? (|(match_vec >> i))
				: ((OCC_W'(i) < occ_q) || (room && (OCC_W'(i) == occ_q))));
			lrl_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl[i]),
				.probe_key (access.access_key),
				.prev_key  (cell_key[i-1]),
				.key       (cell_key[i]),
				.match     (match_vec[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q         <= '0;
			max_entries_q <= MAX_ENTRIES_RST;
			s1_valid_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				max_entries_q <= cfg.max_entries;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				occ_q       <= occ_next;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1 <= access.access_key;
		end
		if (advance) begin
			hit_q         <= hit;
			evicted_q     <= !hit && !room;
			evicted_key_q <= (!hit && !room) ? tail_key : '0;
			fill_count_q  <= CNT_W'(occ_next);
		end
	end

	assign result.valid       = out_valid_q;
	assign result.hit         = hit_q;
	assign result.evicted     = evicted_q;
	assign result.evicted_key = evicted_key_q;
	assign result.fill_count  = fill_count_q;

`ifndef ASSERT_OFF
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(CAPACITY))
		else $error("occupancy exceeds capacity");

	a_unique_match: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> $onehot0(match_vec))
		else $error("key held in more than one cell");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_valid_q))
		else $error("result appeared without an access in flight");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit_q && evicted_q))
		else $error("hit and eviction reported together");
`endif

endmodule

`default_nettype wire
